[rtl/glj_pkg.sv]
// Shared types and constants for the greedy full-justification layout block.
// Used by glj_div, greedy_full_justify_layout_core and glj_checker. No dependencies.

package glj_pkg;

  localparam int unsigned MAX_WIDTH = 64;
  localparam int unsigned MAX_WORDS = 32;

  localparam int unsigned LEN_W  = 7;
  localparam int unsigned REF_W  = 16;
  localparam int unsigned CNT_W  = $clog2(MAX_WORDS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_WORDS);
  localparam int unsigned STEP_W = $clog2(LEN_W + 1);

  localparam logic [LEN_W-1:0] WIDTH_RESET = LEN_W'(16);

  typedef struct packed {
    logic [LEN_W-1:0] word_len;
    logic [REF_W-1:0] word_ref;
    logic             end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [REF_W-1:0] out_ref;
    logic [LEN_W-1:0] out_len;
    logic [LEN_W-1:0] spaces_after;
    logic             line_end;
    logic             run_last;
  } out_beat_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [REF_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic [LEN_W-1:0] spaces;
    logic             line_end;
    logic             run_last;
  } meta_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT_J,
    ST_APPEND,
    ST_EMIT_L
  } state_e;

endpackage

[rtl/glj_div.sv]
// Restoring divider, one quotient bit per cycle: slack / gap count.
// Depends on glj_pkg for widths.

module glj_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [glj_pkg::LEN_W-1:0]      dividend_i,
  input  logic [glj_pkg::IDX_W-1:0]      divisor_i,
  output logic                           busy_o,
  output logic [glj_pkg::LEN_W-1:0]      quotient_o,
  output logic [glj_pkg::IDX_W-1:0]      remainder_o
);

  logic [glj_pkg::STEP_W-1:0] step_q, step_d;
  logic [glj_pkg::LEN_W-1:0]  quo_q, quo_d;
  logic [glj_pkg::IDX_W-1:0]  rem_q, rem_d;
  logic [glj_pkg::IDX_W-1:0]  dsr_q, dsr_d;
  logic [glj_pkg::IDX_W:0]    trial;
  logic                       fits;

  assign trial = {rem_q, quo_q[glj_pkg::LEN_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      step_d = glj_pkg::STEP_W'(glj_pkg::LEN_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (step_q != '0) begin
      step_d = step_q - 1'b1;
      quo_d  = {quo_q[glj_pkg::LEN_W-2:0], fits};
      rem_d  = fits ? glj_pkg::IDX_W'(trial - {1'b0, dsr_q}) : trial[glj_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o      = step_q != '0;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

[rtl/greedy_full_justify_layout_core.sv]
// Greedy full-justification line layout: top level with the line buffer memory.
// A joining word is written to the buffer in ST_APPEND; a close of n > 1 words first runs
// the divider in ST_DIV; every result then passes the buffer read and output registers;
// input stalls meanwhile. A close of a one-word line skips ST_DIV and goes to ST_EMIT_J.
// Reset clears control state and sets line_width to 16; the buffer memory is not cleared.
// Depends on glj_pkg and glj_div.

module greedy_full_justify_layout_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  glj_pkg::in_beat_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output glj_pkg::out_beat_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [glj_pkg::LEN_W-1:0]    cfg_wdata_i
);

  glj_pkg::state_e state_q, state_d;

  logic [glj_pkg::CNT_W-1:0] count_q, count_m1;
  logic [glj_pkg::LEN_W-1:0] used_q, width_q, pad;
  logic [glj_pkg::IDX_W-1:0] idx_q, last_idx;
  logic                      eot_q;
  logic [glj_pkg::LEN_W-1:0] len_q;
  logic [glj_pkg::REF_W-1:0] ref_q;

  glj_pkg::entry_t mem [glj_pkg::MAX_WORDS];
  glj_pkg::entry_t rd_data_q;
  logic            rd_pend_q;
  glj_pkg::meta_t  meta_q, meta_d;

  logic               out_valid_q;
  glj_pkg::out_beat_t out_q;

  logic in_stall, in_accept, close_line, at_last, can_issue;
  logic rd_en, wr_en, div_start, div_busy;
  logic [glj_pkg::LEN_W-1:0] share;
  logic [glj_pkg::IDX_W-1:0] extra;
  logic [glj_pkg::LEN_W:0]   need;

  assign in_accept = in_valid_i && !in_stall;
  assign pad       = (used_q < width_q) ? width_q - used_q : '0;
  assign count_m1  = count_q - 1'b1;
  assign last_idx  = count_m1[glj_pkg::IDX_W-1:0];
  assign at_last   = idx_q == last_idx;
  assign can_issue = !rd_pend_q && (!out_valid_q || !out_stall_i);

  // used + 1 + len, one bit wider so an overlong word cannot wrap
  assign need = {1'b0, used_q} + (glj_pkg::LEN_W+1)'(1) + {1'b0, in_data_i.word_len};
  assign close_line = (count_q != '0) &&
                      ((need > {1'b0, width_q}) ||
                       (count_q >= glj_pkg::CNT_W'(glj_pkg::MAX_WORDS)));

  glj_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (pad),
    .divisor_i   (last_idx),
    .busy_o      (div_busy),
    .quotient_o  (share),
    .remainder_o (extra)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      glj_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (!close_line)              state_d = glj_pkg::ST_APPEND;
          else if (count_q == 'd1)      state_d = glj_pkg::ST_EMIT_J;
          else                          state_d = glj_pkg::ST_DIV;
        end
      end
      glj_pkg::ST_DIV: begin
        if (!div_busy) state_d = glj_pkg::ST_EMIT_J;
      end
      glj_pkg::ST_EMIT_J: begin
        if (rd_en && at_last) state_d = glj_pkg::ST_APPEND;
      end
      glj_pkg::ST_APPEND: begin
        state_d = eot_q ? glj_pkg::ST_EMIT_L : glj_pkg::ST_IDLE;
      end
      glj_pkg::ST_EMIT_L: begin
        if (rd_en && at_last) state_d = glj_pkg::ST_IDLE;
      end
      default: state_d = glj_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    meta_d    = '0;
    unique case (state_q)
      glj_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        div_start = in_accept && close_line && (count_q != 'd1);
      end
      glj_pkg::ST_DIV: begin
      end
      glj_pkg::ST_EMIT_J: begin
        rd_en = can_issue;
        if (at_last) begin
          meta_d.spaces   = (count_q == 'd1) ? pad : '0;
          meta_d.line_end = 1'b1;
          meta_d.run_last = !eot_q;
        end else begin
          meta_d.spaces = share + glj_pkg::LEN_W'(1)
                        + glj_pkg::LEN_W'(idx_q < extra);
        end
      end
      glj_pkg::ST_APPEND: begin
        wr_en = 1'b1;
      end
      glj_pkg::ST_EMIT_L: begin
        rd_en = can_issue;
        if (at_last) begin
          meta_d.spaces   = pad;
          meta_d.line_end = 1'b1;
          meta_d.run_last = 1'b1;
        end else begin
          meta_d.spaces = glj_pkg::LEN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= glj_pkg::ST_IDLE;
      count_q     <= '0;
      used_q      <= '0;
      idx_q       <= '0;
      eot_q       <= 1'b0;
      width_q     <= glj_pkg::WIDTH_RESET;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_en;

      if (cfg_we_i) begin
        width_q <= (cfg_wdata_i > glj_pkg::LEN_W'(glj_pkg::MAX_WIDTH))
                 ? glj_pkg::LEN_W'(glj_pkg::MAX_WIDTH) : cfg_wdata_i;
      end

      if (in_accept) begin
        eot_q <= in_data_i.end_of_text;
        idx_q <= '0;
      end

      if (rd_en) begin
        if (at_last) begin
          idx_q   <= '0;
          count_q <= '0;
          used_q  <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end

      if (wr_en) begin
        count_q <= count_q + 1'b1;
        used_q  <= (count_q == '0) ? len_q : used_q + glj_pkg::LEN_W'(1) + len_q;
      end

      // a read lands only when the output slot is free or being taken
      if (rd_pend_q)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      len_q <= in_data_i.word_len;
      ref_q <= in_data_i.word_ref;
    end
    if (wr_en) mem[count_q[glj_pkg::IDX_W-1:0]] <= '{len: len_q, tag: ref_q};
    if (rd_en) begin
      rd_data_q <= mem[idx_q];
      meta_q    <= meta_d;
    end
    if (rd_pend_q) begin
      out_q.out_ref      <= rd_data_q.tag;
      out_q.out_len      <= rd_data_q.len;
      out_q.spaces_after <= meta_q.spaces;
      out_q.line_end     <= meta_q.line_end;
      out_q.run_last     <= meta_q.run_last;
    end
  end

  assign in_stall_o  = in_stall;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/glj_checker.sv]
// Port-level checks for greedy_full_justify_layout_core, bound to the top level.
// Depends on glj_pkg.

module glj_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input glj_pkg::out_beat_t out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // an accepted word moves the core out of ST_IDLE, so input is never taken back to back
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on back-to-back cycles");

  a_gap_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.line_end |-> out_data_o.spaces_after != '0)
    else $error("inner word without a following space");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.run_last |-> out_data_o.line_end)
    else $error("last result of a beat does not end a line");

endmodule

bind greedy_full_justify_layout_core glj_checker u_glj_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[tb/sv/greedy_full_justify_layout_core_tb.sv]
// Self-checking testbench for greedy_full_justify_layout_core: drives words, predicts
// the per-word layout beats in a scoreboard class and compares every output beat.
// Depends on glj_pkg and the RTL of the layout core.
`timescale 1ns / 1ps

module greedy_full_justify_layout_core_tb;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES = 40;

  class layout_ledger;
    logic [glj_pkg::LEN_W-1:0] line_len [glj_pkg::MAX_WORDS];
    logic [glj_pkg::REF_W-1:0] line_tag [glj_pkg::MAX_WORDS];
    int unsigned               n_words;
    int unsigned               used;
    int unsigned               width;
    int unsigned               fail_count;
    glj_pkg::out_beat_t        placements_due [$];

    function new();
      n_words    = 0;
      used       = 0;
      width      = 16;
      fail_count = 0;
    endfunction

    function void set_width(logic [glj_pkg::LEN_W-1:0] v);
      width = (v > glj_pkg::MAX_WIDTH) ? glj_pkg::MAX_WIDTH : v;
    endfunction

    function int unsigned waiting();
      return placements_due.size();
    endfunction

    function int unsigned pad();
      return (used < width) ? width - used : 0;
    endfunction

    function void place(logic [glj_pkg::REF_W-1:0] tag, logic [glj_pkg::LEN_W-1:0] len,
                        int unsigned sp, logic le);
      glj_pkg::out_beat_t b;
      b.out_ref      = tag;
      b.out_len      = len;
      b.spaces_after = glj_pkg::LEN_W'(sp);
      b.line_end     = le;
      b.run_last     = 1'b0;
      placements_due = {placements_due, b};
    endfunction

    // slack spread over gaps, leftmost gaps take the remainder; one word takes it all
    function void close_justified();
      int unsigned gaps, slack, share, extra, i;
      if (n_words == 1) begin
        place(line_tag[0], line_len[0], pad(), 1'b1);
        return;
      end
      gaps  = n_words - 1;
      slack = pad();
      share = slack / gaps;
      extra = slack % gaps;
      for (i = 0; i < gaps; i++) begin
        place(line_tag[i], line_len[i], 1 + share + ((i < extra) ? 1 : 0), 1'b0);
      end
      place(line_tag[gaps], line_len[gaps], 0, 1'b1);
    endfunction

    function void close_left();
      int unsigned i;
      for (i = 0; i + 1 < n_words; i++) begin
        place(line_tag[i], line_len[i], 1, 1'b0);
      end
      place(line_tag[n_words-1], line_len[n_words-1], pad(), 1'b1);
    endfunction

    function void take_word(glj_pkg::in_beat_t b);
      glj_pkg::out_beat_t tail;
      int unsigned        prior_n;
      prior_n = placements_due.size();
      if (n_words > 0 &&
          (used + 1 + b.word_len > width || n_words >= glj_pkg::MAX_WORDS)) begin
        close_justified();
        n_words = 0;
        used    = 0;
      end
      if (n_words == 0) used = b.word_len;
      else used += 1 + b.word_len;
      line_len[n_words] = b.word_len;
      line_tag[n_words] = b.word_ref;
      n_words++;
      if (b.end_of_text) begin
        close_left();
        n_words = 0;
        used    = 0;
      end
      if (placements_due.size() > prior_n) begin
        tail = placements_due.pop_back();
        tail.run_last = 1'b1;
        placements_due = {placements_due, tail};
      end
    endfunction

    function void match_placement(glj_pkg::out_beat_t got);
      glj_pkg::out_beat_t want;
      if (placements_due.size() == 0) begin
        $error("unexpected beat: out_ref %0h out_len %0d spaces_after %0d",
               got.out_ref, got.out_len, got.spaces_after);
        fail_count++;
        return;
      end
      want = placements_due.pop_front();
      if (got.out_ref !== want.out_ref) begin
        $error("out_ref: expected %0h, actual %0h", want.out_ref, got.out_ref);
        fail_count++;
      end
      if (got.out_len !== want.out_len) begin
        $error("out_len: expected %0d, actual %0d", want.out_len, got.out_len);
        fail_count++;
      end
      if (got.spaces_after !== want.spaces_after) begin
        $error("spaces_after: expected %0d, actual %0d", want.spaces_after, got.spaces_after);
        fail_count++;
      end
      if (got.line_end !== want.line_end) begin
        $error("line_end: expected %0b, actual %0b", want.line_end, got.line_end);
        fail_count++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %0b, actual %0b", want.run_last, got.run_last);
        fail_count++;
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  glj_pkg::in_beat_t         in_data_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  glj_pkg::out_beat_t        out_data_o;
  logic                      cfg_we_i = 1'b0;
  logic [glj_pkg::LEN_W-1:0] cfg_wdata_i = '0;

  layout_ledger ledger = new();
  bit           src_lazy = 1'b0;
  bit           sink_lazy = 1'b0;
  bit           hold_req = 1'b0;
  int unsigned  idle_cycles = 0;

  greedy_full_justify_layout_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stall per beat when sink_lazy, plus one long hold-off on request
  initial begin : sink
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = sink_lazy ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      ledger.match_placement(out_data_o);
    end
  end

  task automatic offer_word(input logic [glj_pkg::LEN_W-1:0] len,
                            input logic [glj_pkg::REF_W-1:0] tag, input logic eot);
    glj_pkg::in_beat_t b;
    int unsigned       gap;
    b.word_len    = len;
    b.word_ref    = tag;
    b.end_of_text = eot;
    gap = src_lazy ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ledger.take_word(b);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.waiting() > 0) @(posedge clk_i);
  endtask

  // width only changes with the block idle; buffered words may remain
  task automatic write_width(input logic [glj_pkg::LEN_W-1:0] v);
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    ledger.set_width(v);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_phase(input logic [glj_pkg::LEN_W-1:0] w, input int unsigned n_beats,
                              input bit hold, input bit pause_mid);
    int unsigned               eff, pick, i;
    logic [glj_pkg::LEN_W-1:0] len;
    logic                      eot;
    write_width(w);
    eff       = (w > glj_pkg::MAX_WIDTH) ? glj_pkg::MAX_WIDTH : w;
    src_lazy  = hold ? 1'b0 : ($urandom_range(0, 2) != 0);
    sink_lazy = $urandom_range(0, 2) != 0;
    if (hold) hold_req = 1'b1;
    for (i = 0; i < n_beats; i++) begin
      if (pause_mid && i == n_beats / 2) settle();
      pick = $urandom_range(0, 9);
      if (pick == 0) len = glj_pkg::LEN_W'($urandom_range(0, glj_pkg::MAX_WIDTH));
      else if (pick == 1) len = glj_pkg::LEN_W'(eff);
      else len = glj_pkg::LEN_W'($urandom_range(0, eff / 3 + 1));
      eot = ($urandom_range(0, 9) == 0) || (i == n_beats - 1 && $urandom_range(0, 1) == 1);
      offer_word(len, glj_pkg::REF_W'($urandom_range(0, 16'hFFFF)), eot);
    end
  endtask

  initial begin : stimulus
    int unsigned i;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset width 16: justified close, one-word lines, zero-length and overlong words
    src_lazy  = 1'b1;
    sink_lazy = 1'b1;
    offer_word(7'd5, 16'h0000, 1'b0);
    offer_word(7'd4, 16'hFFFF, 1'b0);
    offer_word(7'd6, 16'h5555, 1'b0);
    offer_word(7'd16, 16'hAAAA, 1'b0);
    offer_word(7'd0, 16'h0001, 1'b0);
    offer_word(7'd20, 16'h8000, 1'b0);
    offer_word(7'd3, 16'h1234, 1'b0);
    offer_word(7'd3, 16'h4321, 1'b1);
    offer_word(7'd64, 16'h7FFF, 1'b1);
    // final word also closes the buffered line
    offer_word(7'd10, 16'h0F0F, 1'b0);
    offer_word(7'd10, 16'hF0F0, 1'b1);

    // zero width: every word alone, no padding
    write_width(7'd0);
    offer_word(7'd0, 16'h00FF, 1'b0);
    offer_word(7'd3, 16'hFF00, 1'b0);
    offer_word(7'd0, 16'h0F00, 1'b1);

    // width saturates to the maximum
    write_width(7'd127);
    offer_word(7'd30, 16'h3333, 1'b0);
    offer_word(7'd33, 16'hCCCC, 1'b0);
    offer_word(7'd64, 16'h6666, 1'b0);
    offer_word(7'd1, 16'h9999, 1'b1);

    write_width(7'd1);
    offer_word(7'd1, 16'h1111, 1'b0);
    offer_word(7'd0, 16'h2222, 1'b0);
    offer_word(7'd2, 16'hEEEE, 1'b1);

    // full line buffer: the 33rd word forces the close, then ends the text
    write_width(7'd64);
    src_lazy = 1'b0;
    for (i = 0; i < glj_pkg::MAX_WORDS + 1; i++) begin
      offer_word(glj_pkg::LEN_W'($urandom_range(0, 1)),
                 glj_pkg::REF_W'($urandom_range(0, 16'hFFFF)), i == glj_pkg::MAX_WORDS);
    end

    random_phase(7'd64, 10, 1'b1, 1'b0);
    random_phase(7'd8, 8, 1'b0, 1'b1);
    random_phase(7'd1, 6, 1'b0, 1'b0);
    random_phase(7'd0, 4, 1'b0, 1'b0);
    random_phase(7'd100, 6, 1'b0, 1'b0);
    random_phase(glj_pkg::LEN_W'($urandom_range(2, 64)), 6, 1'b0, 1'b0);
    random_phase(glj_pkg::LEN_W'($urandom_range(0, 127)), 6, 1'b0, 1'b0);
    random_phase(7'd16, 6, 1'b0, 1'b0);
    random_phase(glj_pkg::LEN_W'($urandom_range(2, 64)), 6, 1'b0, 1'b1);

    settle();
    repeat (60) @(posedge clk_i);
    if (ledger.fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/glj_pkg.sv
rtl/glj_div.sv
rtl/greedy_full_justify_layout_core.sv
rtl/glj_checker.sv
tb/sv/greedy_full_justify_layout_core_tb.sv
